@@ design/sysex_header_match_7to8_unpacker_unit_macros.svh @@
// Assertion macros shared by the SysEx header matcher and unpacker.
`ifndef SYSEX_HEADER_MATCH_7TO8_UNPACKER_UNIT_MACROS_SVH
`define SYSEX_HEADER_MATCH_7TO8_UNPACKER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SHMU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SHMU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define SHMU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg)
`define SHMU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ design/shmu_pkg.sv @@
// Types and constants of the SysEx header matcher and 7-to-8 bit unpacker.
`default_nettype none

package shmu_pkg;

	// Longest header that can be matched and the byte buffer size.
	localparam int MAX_HEADER = 8;
	localparam int MAX_BYTES  = 128;

	// Bytes at or above this value are status bytes.
	localparam logic [7:0] STATUS_MIN = 8'h80;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_HEADER_LENGTH = 2'd0;
	localparam logic [1:0] REG_HEADER_BYTES  = 2'd1;
	localparam logic [1:0] REG_FOOTER_BYTE   = 2'd2;

	// Register reset values.
	localparam logic [3:0]  HEADER_LENGTH_RESET = 4'd1;
	localparam logic [63:0] HEADER_BYTES_RESET  = 64'h0000_0000_0000_00F0;
	localparam logic [7:0]  FOOTER_BYTE_RESET   = 8'hF7;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_DATA  = 2'd1,
		KIND_END   = 2'd2
	} event_kind_t;

endpackage

`default_nettype wire

@@ design/sysex_header_match_7to8_unpacker_unit.sv @@
// Top level of the SysEx header matcher and 7-to-8 bit unpacker.
`default_nettype none

// This block takes one MIDI byte per request and produces at most one event
// per byte. While idle it matches incoming bytes against a configured header
// of one to eight bytes; a mismatching byte drops the match back to the start
// and is not compared again with the first header byte. When the header is
// complete, a start event is sent. Inside a message, every data byte below
// 0x80 contributes its seven low bits, bit 6 first, to an 8-bit accumulator,
// and each completed byte is sent as a data event with its index. Status
// bytes other than the footer are ignored. The footer sends an end event with
// the number of bytes kept and an overflow flag, drops any leftover bits and
// returns to idle. Bytes past the 128-byte buffer are dropped and flagged.
// Each byte passes through the input register, where all decoding is
// done, and then through the result register, and one byte is accepted
// every cycle as long as events are taken. The
// result register is the only buffer on the output side: when it is full and
// not being taken, a byte that would produce an event waits in the input
// register, while bytes that produce no event still pass through.
// Configuration registers take effect at once and should be written only
// while no request is in flight.

`include "sysex_header_match_7to8_unpacker_unit_macros.svh"

module sysex_header_match_7to8_unpacker_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,

	// Configuration write port
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [63:0]                 cfg_data,

	// Incoming MIDI bytes
	input  wire logic                        midi_valid,
	output logic                             midi_ready,
	input  wire logic [7:0]                  midi_byte,

	// Outgoing events
	output logic                             event_valid,
	input  wire logic                        event_ready,
	output logic [1:0]                       event_kind,
	output logic [7:0]                       data_byte,
	output logic [7:0]                       byte_count,
	output logic                             overflow
);
	import shmu_pkg::*;

	// Configuration registers.
	logic [3:0]  header_length_q;
	logic [63:0] header_bytes_q;
	logic [7:0]  footer_byte_q;

	// Message state.
	logic        in_msg_q;
	logic [3:0]  match_cnt_q;
	logic [6:0]  acc_q;
	logic [2:0]  bit_cnt_q;
	logic [7:0]  bytes_q;
	logic        ovf_q;

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;

	// Result register.
	logic        out_valid_q;
	event_kind_t out_kind_q;
	logic [7:0]  out_data_q;
	logic [7:0]  out_count_q;
	logic        out_ovf_q;

	// Decode results of the byte in the input register.
	logic        res_valid;
	event_kind_t res_kind;
	logic [7:0]  res_data;
	logic [7:0]  res_count;
	logic        res_ovf;

	logic        nxt_in_msg;
	logic [3:0]  nxt_match_cnt;
	logic [6:0]  nxt_acc;
	logic [2:0]  nxt_bit_cnt;
	logic [7:0]  nxt_bytes;
	logic        nxt_ovf;

	logic [3:0]  eff_len;
	logic [3:0]  match_inc;
	logic [7:0]  expect_byte;
	logic [2:0]  take_bits;
	logic [2:0]  rest_bits;
	logic [7:0]  full_byte;

	logic        out_free;
	logic        advance;
	logic        in_accept;

	// The result register can take a new event when it is empty or being
	// emptied in this cycle. A byte leaves the input register when it either
	// makes no event or its event has room.
	assign out_free   = !out_valid_q || event_ready;
	assign advance    = valid_s1 && (out_free || !res_valid);
	assign midi_ready = !valid_s1 || advance;
	assign in_accept  = midi_valid && midi_ready;

	// A header length of zero acts as one, and values past the longest
	// header act as the longest header.
	always_comb begin
		if (header_length_q == 4'd0) begin
			eff_len = 4'd1;
		end else if (header_length_q > 4'(MAX_HEADER)) begin
			eff_len = 4'(MAX_HEADER);
		end else begin
			eff_len = header_length_q;
		end
	end

	assign match_inc   = match_cnt_q + 4'd1;
	assign expect_byte = header_bytes_q[{match_cnt_q[2:0], 3'b000} +: 8];

	// The accumulator holds bit_cnt_q bits; the new byte supplies the rest
	// of the output byte from its top, and its low bits stay behind.
	assign take_bits = 3'(4'd8 - {1'b0, bit_cnt_q});
	assign rest_bits = bit_cnt_q - 3'd1;
	assign full_byte = 8'({1'b0, acc_q} << take_bits) | 8'(byte_s1 >> rest_bits);

	always_comb begin
		res_valid     = 1'b0;
		res_kind      = KIND_START;
		res_data      = 8'd0;
		res_count     = 8'd0;
		res_ovf       = 1'b0;
		nxt_in_msg    = in_msg_q;
		nxt_match_cnt = match_cnt_q;
		nxt_acc       = acc_q;
		nxt_bit_cnt   = bit_cnt_q;
		nxt_bytes     = bytes_q;
		nxt_ovf       = ovf_q;

		if (!in_msg_q) begin
			// Header matching. A mismatch restarts the match without
			// comparing this byte with the first header byte again.
			if (byte_s1 != expect_byte) begin
				nxt_match_cnt = 4'd0;
			end else if (match_inc >= eff_len) begin
				nxt_in_msg    = 1'b1;
				nxt_match_cnt = 4'd0;
				nxt_acc       = 7'd0;
				nxt_bit_cnt   = 3'd0;
				nxt_bytes     = 8'd0;
				nxt_ovf       = 1'b0;
				res_valid     = 1'b1;
				res_kind      = KIND_START;
			end else begin
				nxt_match_cnt = match_inc;
			end
		end else if (byte_s1 >= STATUS_MIN) begin
			// Only the footer ends the message; other status bytes are ignored.
			if (byte_s1 == footer_byte_q) begin
				nxt_in_msg    = 1'b0;
				nxt_match_cnt = 4'd0;
				nxt_acc       = 7'd0;
				nxt_bit_cnt   = 3'd0;
				res_valid     = 1'b1;
				res_kind      = KIND_END;
				res_count     = bytes_q;
				res_ovf       = ovf_q;
			end
		end else if (bit_cnt_q == 3'd0) begin
			// First seven bits of a new output byte.
			nxt_acc     = byte_s1[6:0];
			nxt_bit_cnt = 3'd7;
		end else begin
			nxt_acc     = byte_s1[6:0] & ~(7'h7F << rest_bits);
			nxt_bit_cnt = rest_bits;
			if (bytes_q >= 8'(MAX_BYTES)) begin
				// Buffer full: the completed byte is dropped.
				nxt_bytes = 8'(MAX_BYTES);
				nxt_ovf   = 1'b1;
			end else begin
				res_valid = 1'b1;
				res_kind  = KIND_DATA;
				res_data  = full_byte;
				res_count = bytes_q;
				nxt_bytes = bytes_q + 8'd1;
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_length_q <= HEADER_LENGTH_RESET;
			header_bytes_q  <= HEADER_BYTES_RESET;
			footer_byte_q   <= FOOTER_BYTE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HEADER_LENGTH: header_length_q <= cfg_data[3:0];
				REG_HEADER_BYTES:  header_bytes_q  <= cfg_data;
				REG_FOOTER_BYTE:   footer_byte_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			byte_s1 <= midi_byte;
		end
	end

	// Message state advances when the byte leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q    <= 1'b0;
			match_cnt_q <= 4'd0;
			acc_q       <= 7'd0;
			bit_cnt_q   <= 3'd0;
			bytes_q     <= 8'd0;
			ovf_q       <= 1'b0;
		end else if (advance) begin
			in_msg_q    <= nxt_in_msg;
			match_cnt_q <= nxt_match_cnt;
			acc_q       <= nxt_acc;
			bit_cnt_q   <= nxt_bit_cnt;
			bytes_q     <= nxt_bytes;
			ovf_q       <= nxt_ovf;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (event_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_kind_q  <= res_kind;
			out_data_q  <= res_data;
			out_count_q <= res_count;
			out_ovf_q   <= res_ovf;
		end
	end

	assign event_valid = out_valid_q;
	assign event_kind  = out_kind_q;
	assign data_byte   = out_data_q;
	assign byte_count  = out_count_q;
	assign overflow    = out_ovf_q;

	// A start event always enters a message.
	`SHMU_ASSERT_NEXT(a_start_enters_msg, clk, arst_n,
		advance && res_valid && res_kind == KIND_START, in_msg_q,
		"start event did not enter a message")

	// The byte count never passes the buffer size.
	`SHMU_ASSERT_IMPLIES(a_bytes_bounded, clk, arst_n,
		1'b1, bytes_q <= 8'(MAX_BYTES),
		"byte count passed the buffer size")

	// Only data events carry a decoded byte, and only end events an overflow.
	`SHMU_ASSERT_IMPLIES(a_payload_zeroed, clk, arst_n,
		out_valid_q && out_kind_q != KIND_DATA,
		out_data_q == 8'd0 && (out_ovf_q == 1'b0 || out_kind_q == KIND_END),
		"event carries payload that does not belong to its kind")

	// The header match counter is idle while inside a message.
	`SHMU_ASSERT_IMPLIES(a_match_idle_in_msg, clk, arst_n,
		in_msg_q, match_cnt_q == 4'd0,
		"header match count nonzero inside a message")

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the SysEx header matcher and 7-to-8 bit unpacker.
`timescale 1ns / 100ps

// The testbench sends MIDI bytes into the block over a valid/ready channel and
// takes events from the other side while the ready line idles at random. Every
// accepted request runs through a cycle-free model of the matcher and the
// unpacker that is kept in this file. The model queues the event that the byte
// should cause, and one checker process compares each event that is taken,
// field by field, with the oldest queued one. Registers are written only once
// the block has drained, so the model and the block always see the same setting.

module tb;
	import shmu_pkg::*;

	localparam int          CLK_PERIOD     = 12;
	localparam int          RESET_CYCLES   = 12;
	// A byte that causes no event may still be in the input register when the
	// last event leaves, so the drain keeps waiting past that point.
	localparam int          DRAIN_CYCLES   = 4;
	localparam int          HOLD_CYCLES    = 300;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          RANDOM_ITEMS   = 730;
	// Index 3 does not select a register; a write to it must change nothing.
	localparam logic [1:0]  REG_UNUSED     = 2'd3;

	typedef struct {
		event_kind_t kind;
		logic [7:0]  data;
		logic [7:0]  count;
		logic        ovf;
	} midi_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        midi_valid = 1'b0;
	logic        midi_ready;
	logic [7:0]  midi_byte = '0;
	logic        event_valid;
	logic        event_ready = 1'b0;
	logic [1:0]  event_kind;
	logic [7:0]  data_byte;
	logic [7:0]  byte_count;
	logic        overflow;

	// Register copies that the model decodes with.
	logic [3:0]  cfg_hdr_len = HEADER_LENGTH_RESET;
	logic [63:0] cfg_hdr_bytes = HEADER_BYTES_RESET;
	logic [7:0]  cfg_footer = FOOTER_BYTE_RESET;

	// Model state: header progress, the partial byte and the message totals.
	logic        in_msg = 1'b0;
	logic [3:0]  match_cnt = '0;
	logic [7:0]  acc_bits = '0;
	logic [2:0]  acc_fill = '0;
	logic [7:0]  kept = '0;
	logic        dropped = 1'b0;

	midi_event_t expected_events[$];

	int  errors = 0;
	int  bytes_sent = 0;
	int  idle_cycles = 0;
	bit  tx_steady = 1'b0;
	bit  rx_steady = 1'b0;
	bit  hold_request = 1'b0;
	int  hold_left = 0;
	int  stall_left = 0;

	sysex_header_match_7to8_unpacker_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.midi_valid  (midi_valid),
		.midi_ready  (midi_ready),
		.midi_byte   (midi_byte),
		.event_valid (event_valid),
		.event_ready (event_ready),
		.event_kind  (event_kind),
		.data_byte   (data_byte),
		.byte_count  (byte_count),
		.overflow    (overflow)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// A header length of zero behaves as one, and anything past the longest
	// header behaves as the longest header.
	function automatic int header_span();
		if (cfg_hdr_len == 4'd0)
			return 1;
		if (int'(cfg_hdr_len) > MAX_HEADER)
			return MAX_HEADER;
		return int'(cfg_hdr_len);
	endfunction

	function automatic void queue_event(event_kind_t k, logic [7:0] d, logic [7:0] c,
			logic o);
		expected_events.push_back('{k, d, c, o});
	endfunction

	// Advances the model by one accepted byte and queues the event it causes.
	function automatic void decode_midi_byte(logic [7:0] b);
		logic [7:0] want;
		logic [7:0] full;
		int take;
		int rest;
		if (!in_msg) begin
			// A mismatch starts the header over, and the offending byte is not
			// tried again as the first header byte.
			want = cfg_hdr_bytes[8 * int'(match_cnt[2:0]) +: 8];
			if (b != want) begin
				match_cnt = '0;
			end else begin
				match_cnt = 4'(match_cnt + 4'd1);
				// The count may already be past a length that was shortened
				// during the match, so the test is "at least".
				if (int'(match_cnt) >= header_span()) begin
					in_msg = 1'b1;
					match_cnt = '0;
					acc_bits = '0;
					acc_fill = '0;
					kept = '0;
					dropped = 1'b0;
					queue_event(KIND_START, 8'd0, 8'd0, 1'b0);
				end
			end
		end else if (b >= STATUS_MIN) begin
			// Status bytes other than the footer are ignored. A footer below
			// the status range never gets here, since such a byte is data.
			if (b == cfg_footer) begin
				queue_event(KIND_END, 8'd0, kept, dropped);
				in_msg = 1'b0;
				match_cnt = '0;
				acc_bits = '0;
				acc_fill = '0;
			end
		end else if (acc_fill == 3'd0) begin
			acc_bits = {1'b0, b[6:0]};
			acc_fill = 3'd7;
		end else begin
			// Bit 6 arrives first: the top bits of this byte finish the held
			// byte and the rest stay behind for the next one.
			take = 8 - int'(acc_fill);
			rest = 7 - take;
			full = 8'((int'(acc_bits) << take) | (int'(b) >> rest));
			acc_bits = 8'(int'(b) & ((1 << rest) - 1));
			acc_fill = 3'(rest);
			if (int'(kept) >= MAX_BYTES) begin
				kept = 8'(MAX_BYTES);
				dropped = 1'b1;
			end else begin
				queue_event(KIND_DATA, full, kept, 1'b0);
				kept = 8'(kept + 8'd1);
			end
		end
	endfunction

	// Receiver side. It normally takes events at random, runs with ready held
	// high when asked to, and on request holds off for a long stretch so that
	// the block backs up into its input.
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			event_ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES - 1;
			event_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left = stall_left - 1;
			event_ready <= 1'b0;
		end else if (rx_steady) begin
			event_ready <= 1'b1;
		end else begin : rx_roll
			int r;
			r = $urandom_range(0, 99);
			if (r < 60) begin
				event_ready <= 1'b1;
			end else begin
				// Most stalls are short; a few last much longer.
				stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(7, 39);
				event_ready <= 1'b0;
			end
		end
	end

	// Every event taken is checked against the oldest one the model queued.
	always @(posedge clk) begin : check_events
		midi_event_t want;
		if (arst_n && event_valid && event_ready) begin
			if (expected_events.size() == 0) begin
				$error("event with no request to cause it: kind %0d data %0h count %0d",
					event_kind, data_byte, byte_count);
				errors = errors + 1;
			end else begin
				want = expected_events.pop_front();
				if (event_kind !== want.kind) begin
					$error("event_kind: expected %0d, got %0d", want.kind, event_kind);
					errors = errors + 1;
				end
				if (data_byte !== want.data) begin
					$error("data_byte: expected %0h, got %0h", want.data, data_byte);
					errors = errors + 1;
				end
				if (byte_count !== want.count) begin
					$error("byte_count: expected %0d, got %0d", want.count, byte_count);
					errors = errors + 1;
				end
				if (overflow !== want.ovf) begin
					$error("overflow: expected %0d, got %0d", want.ovf, overflow);
					errors = errors + 1;
				end
			end
		end
	end

	// The run ends as a failure once neither side has moved for too long.
	always @(posedge clk) begin
		if ((midi_valid && midi_ready) || (event_valid && event_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("sysex_header_match_7to8_unpacker_unit regression: fail");
			$finish;
		end
	end

	function automatic int tx_gap();
		int r;
		if (tx_steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one byte after an optional gap and returns at the edge where the
	// request is taken. Valid stays high between back-to-back requests.
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = tx_gap();
		if (gap > 0) begin
			midi_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		midi_valid <= 1'b1;
		midi_byte <= b;
		@(posedge clk);
		while (!midi_ready) @(posedge clk);
		decode_midi_byte(b);
		bytes_sent = bytes_sent + 1;
	endtask

	// Waits until every queued event has been taken and the pipe is empty.
	task automatic drain();
		midi_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_HEADER_LENGTH: cfg_hdr_len = val[3:0];
			REG_HEADER_BYTES:  cfg_hdr_bytes = val;
			REG_FOOTER_BYTE:   cfg_footer = val[7:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input logic [3:0] len, input logic [63:0] hdr,
			input logic [7:0] foot);
		write_reg(REG_HEADER_LENGTH, {60'd0, len});
		write_reg(REG_HEADER_BYTES, hdr);
		write_reg(REG_FOOTER_BYTE, {56'd0, foot});
	endtask

	// Sends the configured header, then data bytes and the footer. A broken
	// message stops the header early and follows it with a random byte. Noise
	// puts stray status bytes between the data bytes.
	task automatic send_message(input int n_data, input bit broken, input bit noisy);
		int span;
		int cut;
		span = header_span();
		cut = broken ? $urandom_range(0, span - 1) : span;
		for (int k = 0; k < cut; k++)
			send_byte(cfg_hdr_bytes[8 * k +: 8]);
		if (broken) begin
			send_byte(8'($urandom_range(0, 255)));
		end else begin
			for (int k = 0; k < n_data; k++) begin
				if (noisy && $urandom_range(0, 15) == 0)
					send_byte(8'($urandom_range(128, 255)));
				else
					send_byte(8'($urandom_range(0, 127)));
			end
			send_byte(cfg_footer);
		end
	endtask

	// Reset settings: a one-byte header and the usual end byte. Stray bytes
	// before the header, status bytes inside the message and a footer that
	// arrives with bits left over are all covered here.
	task automatic test_default_message();
		send_byte(8'hFF);
		send_byte(8'hF0);
		send_byte(8'h7F);
		send_byte(8'h00);
		send_byte(8'h90);
		send_byte(8'h7F);
		send_byte(8'h00);
		send_byte(8'h55);
		send_byte(8'h80);
		send_byte(8'h2A);
		send_byte(8'hF7);
	endtask

	// Header matching: a repeated first byte that must not restart the match,
	// a length shortened while a match is under way, and a length of zero.
	task automatic test_header_rules();
		drain();
		write_reg(REG_HEADER_LENGTH, 64'd3);
		write_reg(REG_HEADER_BYTES, 64'h0000_0000_0010_43F0);
		send_byte(8'hF0);
		send_byte(8'hF0);
		send_byte(8'h43);
		send_byte(8'h10);
		send_byte(8'hF0);
		send_byte(8'h43);
		send_byte(8'h10);
		send_byte(8'hF7);
		send_byte(8'hF0);
		send_byte(8'h43);
		drain();
		write_reg(REG_HEADER_LENGTH, 64'd1);
		send_byte(8'h10);
		send_byte(8'hF7);
		drain();
		write_reg(REG_HEADER_LENGTH, 64'd0);
		send_byte(8'hF0);
		send_byte(8'hF7);
	endtask

	// A footer value below the status range is taken as data and never ends
	// the message, so the real footer is put back mid-message to close it.
	task automatic test_footer_as_data();
		drain();
		write_reg(REG_FOOTER_BYTE, 64'h30);
		send_byte(8'hF0);
		send_byte(8'h30);
		send_byte(8'h30);
		send_byte(8'hF7);
		drain();
		write_reg(REG_FOOTER_BYTE, 64'hF7);
		send_byte(8'hF7);
	endtask

	// Register extremes: an all-ones header at full length with the lowest
	// footer, then an all-zeros header with an oversize length and the highest
	// footer. A write to the unused index must leave everything as it was.
	task automatic test_register_extremes();
		drain();
		write_all(4'd8, '1, 8'h80);
		send_message(5, 1'b0, 1'b0);
		drain();
		write_all(4'd15, '0, 8'hFF);
		write_reg(REG_UNUSED, {$urandom, $urandom});
		send_message(6, 1'b0, 1'b0);
	endtask

	// More completed bytes than the buffer holds: the surplus is dropped, the
	// count saturates and the end event flags it. The next message starts clean.
	task automatic test_buffer_overflow();
		drain();
		write_all(HEADER_LENGTH_RESET, HEADER_BYTES_RESET, FOOTER_BYTE_RESET);
		send_message(160, 1'b0, 1'b0);
		send_message(3, 1'b0, 1'b0);
	endtask

	// The receiver holds off for a long stretch while the sender keeps offering
	// requests, so the result register fills and the input stalls.
	task automatic test_backpressure();
		drain();
		tx_steady = 1'b1;
		hold_request = 1'b1;
		while (hold_left == 0) @(posedge clk);
		send_message(40, 1'b0, 1'b1);
		tx_steady = 1'b0;
	endtask

	// After a broken message, the sender stops mid-message until every queued
	// event has come out, then carries on with the same message.
	task automatic test_drain_pause();
		drain();
		send_message(0, 1'b1, 1'b0);
		for (int k = 0; k < header_span(); k++)
			send_byte(cfg_hdr_bytes[8 * k +: 8]);
		repeat (6) send_byte(8'($urandom_range(0, 127)));
		midi_valid <= 1'b0;
		while (expected_events.size() != 0) @(posedge clk);
		repeat (6) send_byte(8'($urandom_range(0, 127)));
		send_byte(cfg_footer);
	endtask

	// Random phases, each with its own settings. Most traffic is complete
	// messages with random content; the rest is cut-off headers and loose
	// bytes. Every fourth phase runs with no idling on either side.
	task automatic test_random_traffic();
		int target;
		int phase;
		int r;
		int len_pick;
		logic [3:0] len;
		target = bytes_sent + RANDOM_ITEMS;
		phase = 0;
		while (bytes_sent < target) begin
			drain();
			len_pick = $urandom_range(0, 19);
			if (len_pick == 0)
				len = 4'd0;
			else if (len_pick == 1)
				len = 4'($urandom_range(9, 15));
			else if (len_pick < 12)
				len = 4'($urandom_range(1, 3));
			else
				len = 4'($urandom_range(4, 8));
			write_all(len, {$urandom, $urandom}, 8'($urandom_range(128, 255)));
			if ($urandom_range(0, 4) == 0)
				write_reg(REG_UNUSED, {$urandom, $urandom});
			tx_steady = (phase % 4 == 1);
			rx_steady = (phase % 4 == 1);
			repeat ($urandom_range(3, 8)) begin
				r = $urandom_range(0, 9);
				if (r < 7)
					send_message(($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) :
						$urandom_range(0, 12), 1'b0, 1'b1);
				else if (r < 9)
					send_message(0, 1'b1, 1'b0);
				else
					repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
			end
			phase = phase + 1;
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_message();
		test_header_rules();
		test_footer_as_data();
		test_register_extremes();
		test_buffer_overflow();
		test_backpressure();
		test_drain_pause();
		test_random_traffic();
		drain();

		if (errors == 0 && expected_events.size() == 0)
			$display("sysex_header_match_7to8_unpacker_unit regression: pass");
		else
			$display("sysex_header_match_7to8_unpacker_unit regression: fail");
		$finish;
	end

endmodule
